// ===== src/uuencode_line_encoder_defines.svh =====
// assertion macros for the uuencode line encoder checker
`ifndef UUENCODE_LINE_ENCODER_DEFINES_SVH
`define UUENCODE_LINE_ENCODER_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define ULE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uuencode line encoder: same-cycle check failed");

// next-cycle implication, off while reset is asserted
`define ULE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uuencode line encoder: next-cycle check failed");

// checked at every edge, reset included
`define ULE_ASSERT_ALWAYS(lbl, clk, cons) \
    lbl: assert property (@(posedge clk) (cons)) \
        else $error("uuencode line encoder: invariant failed");

`endif

// ===== src/ule_pkg.sv =====
`default_nettype none

package ule_pkg;

    localparam int CHARS_PER_LINE = 60;
    localparam int STORE_DEPTH    = 60;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int COUNT_W        = $clog2(STORE_DEPTH + 1);
    localparam int GROUP_W        = 6;
    localparam int BYTE_W         = 8;
    localparam int ACC_W          = 12;
    localparam int BITS_W         = 4;
    localparam int CHAR_W         = 7;

    localparam logic [COUNT_W-1:0] LINE_FULL  = COUNT_W'(CHARS_PER_LINE);
    localparam logic [COUNT_W-1:0] STORE_FULL = COUNT_W'(STORE_DEPTH);

    localparam logic [BITS_W-1:0] BITS_GROUP     = BITS_W'(GROUP_W);
    localparam logic [BITS_W-1:0] BITS_TWO_GROUP = BITS_W'(2 * GROUP_W);
    localparam logic [BITS_W-1:0] BITS_BYTE      = BITS_W'(BYTE_W);
    localparam logic [BITS_W-1:0] BITS_STEP      = BITS_W'(BYTE_W - GROUP_W);
    localparam logic [BITS_W-1:0] BITS_LEFT_MAX  = BITS_W'(2 * (BYTE_W - GROUP_W));

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = CHAR_W'(10);
    localparam logic [CHAR_W-1:0] ZERO_CHAR    = CHAR_W'(8'h60);
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = CHAR_W'(8'h20);

    typedef enum logic [1:0] {
        SEL_LEN,
        SEL_CHR,
        SEL_NL
    } out_sel_t;

    typedef struct packed {
        logic     load;
        logic     write_group;
        logic     pad;
        logic     clear_line;
        logic     clear_all;
        logic     out_load;
        out_sel_t out_sel;
        logic     rd_first;
        logic     rd_step;
    } dp_cmd_t;

    typedef struct packed {
        logic bits_is_max;
        logic bits_zero;
        logic bits_after_ge_group;
        logic bits_after_zero;
        logic line_full_after;
        logic bytes_zero;
        logic chars_zero;
        logic rd_done;
        logic out_free;
    } dp_sts_t;

    function automatic logic [CHAR_W-1:0] map_group(input logic [GROUP_W-1:0] v);
        logic [CHAR_W-1:0] ch;
        ch = (v == '0) ? ZERO_CHAR : SPACE_CHAR + CHAR_W'(v);
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== src/ule_ram.sv =====
`default_nettype none

module ule_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 60
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/ule_ctrl.sv =====
`default_nettype none

module ule_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic            final_byte,
    input  wire ule_pkg::dp_sts_t sts,
    output ule_pkg::dp_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GROUP,
        ST_FIN,
        ST_LEN,
        ST_CHR,
        ST_NL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   final_pend_reg;
    logic   final_pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            final_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            final_pend_reg <= final_pend_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd             = '0;
        cmd.out_sel     = ule_pkg::SEL_LEN;
        state_next      = state_reg;
        final_pend_next = final_pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load        = 1'b1;
                    final_pend_next = final_byte;
                    if (sts.bits_is_max)
                    begin
                        state_next = ST_GROUP;
                    end
                    else if (final_byte)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_GROUP:
            begin
                cmd.write_group = 1'b1;
                if (sts.bits_after_ge_group)
                begin
                    state_next = ST_GROUP;
                end
                else if (sts.bits_after_zero && sts.line_full_after)
                begin
                    state_next = ST_LEN;
                end
                else if (final_pend_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (!sts.bits_zero)
                begin
                    cmd.pad    = 1'b1;
                    state_next = ST_GROUP;
                end
                else if (!sts.bytes_zero)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    cmd.clear_all   = 1'b1;
                    final_pend_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_LEN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = ule_pkg::SEL_LEN;
                    cmd.rd_first = 1'b1;
                    state_next   = sts.chars_zero ? ST_NL : ST_CHR;
                end
            end
            ST_CHR:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = ule_pkg::SEL_CHR;
                    if (sts.rd_done)
                    begin
                        state_next = ST_NL;
                    end
                    else
                    begin
                        cmd.rd_step = 1'b1;
                    end
                end
            end
            ST_NL:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = ule_pkg::SEL_NL;
                    cmd.clear_line = 1'b1;
                    state_next     = final_pend_reg ? ST_FIN : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/ule_datapath.sv =====
`default_nettype none

module ule_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ule_pkg::dp_cmd_t              cmd,
    output ule_pkg::dp_sts_t                   sts,
    input  wire logic [ule_pkg::BYTE_W-1:0]    data_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [ule_pkg::CHAR_W-1:0]    out_char,
    output logic                               line_last
);

    logic [ule_pkg::ACC_W-1:0]   acc_reg;
    logic [ule_pkg::ACC_W-1:0]   acc_next;
    logic [ule_pkg::BITS_W-1:0]  bits_reg;
    logic [ule_pkg::BITS_W-1:0]  bits_next;
    logic [ule_pkg::COUNT_W-1:0] chars_reg;
    logic [ule_pkg::COUNT_W-1:0] chars_next;
    logic [ule_pkg::GROUP_W-1:0] bytes_reg;
    logic [ule_pkg::GROUP_W-1:0] bytes_next;
    logic [ule_pkg::COUNT_W-1:0] rd_idx_reg;
    logic [ule_pkg::COUNT_W-1:0] rd_idx_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [ule_pkg::CHAR_W-1:0]  out_char_reg;
    logic [ule_pkg::CHAR_W-1:0]  out_char_next;
    logic                        line_last_reg;
    logic                        line_last_next;

    logic [ule_pkg::ACC_W-1:0]   acc_in;
    logic [ule_pkg::GROUP_W-1:0] group_val;
    logic                        store_ok;
    logic                        ram_we;
    logic                        ram_re;
    logic [ule_pkg::ADDR_W-1:0]  ram_raddr;
    logic [ule_pkg::GROUP_W-1:0] ram_rdata;
    logic                        out_free;

    // new byte lands just below the leftover bits, msb first
    assign acc_in = acc_reg
        | ({data_byte, {(ule_pkg::ACC_W - ule_pkg::BYTE_W){1'b0}}} >> bits_reg);

    assign group_val = cmd.load ? acc_in[ule_pkg::ACC_W-1 -: ule_pkg::GROUP_W]
                                : acc_reg[ule_pkg::ACC_W-1 -: ule_pkg::GROUP_W];
    assign store_ok  = (chars_reg < ule_pkg::STORE_FULL);
    assign ram_we    = (cmd.load || cmd.write_group) && store_ok;
    assign ram_re    = cmd.rd_first || cmd.rd_step;
    assign ram_raddr = cmd.rd_first ? '0 : rd_idx_reg[ule_pkg::ADDR_W-1:0];
    assign out_free  = !out_valid_reg || !out_stall;

    ule_ram #(
        .WIDTH (ule_pkg::GROUP_W),
        .DEPTH (ule_pkg::STORE_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (chars_reg[ule_pkg::ADDR_W-1:0]),
        .wdata (group_val),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        acc_next    = acc_reg;
        bits_next   = bits_reg;
        chars_next  = chars_reg;
        bytes_next  = bytes_reg;
        rd_idx_next = rd_idx_reg;
        if (cmd.load)
        begin
            acc_next   = acc_in << ule_pkg::GROUP_W;
            bits_next  = bits_reg + ule_pkg::BITS_STEP;
            bytes_next = bytes_reg + ule_pkg::GROUP_W'(1);
        end
        if (cmd.write_group)
        begin
            acc_next  = acc_reg << ule_pkg::GROUP_W;
            bits_next = bits_reg - ule_pkg::BITS_GROUP;
        end
        if (cmd.pad)
        begin
            bits_next = bits_reg + ule_pkg::BITS_BYTE;
        end
        if (ram_we)
        begin
            chars_next = chars_reg + ule_pkg::COUNT_W'(1);
        end
        if (cmd.clear_line)
        begin
            chars_next = '0;
            bytes_next = '0;
        end
        if (cmd.clear_all)
        begin
            acc_next   = '0;
            bits_next  = '0;
            chars_next = '0;
            bytes_next = '0;
        end
        if (ram_re)
        begin
            rd_idx_next = ule_pkg::COUNT_W'(ram_raddr) + ule_pkg::COUNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        line_last_next = line_last_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            line_last_next = (cmd.out_sel == ule_pkg::SEL_NL);
            case (cmd.out_sel)
                ule_pkg::SEL_LEN: out_char_next = ule_pkg::map_group(bytes_reg);
                ule_pkg::SEL_CHR: out_char_next = ule_pkg::map_group(ram_rdata);
                ule_pkg::SEL_NL:  out_char_next = ule_pkg::NEWLINE_CHAR;
                default:          out_char_next = ule_pkg::NEWLINE_CHAR;
            endcase
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            bits_reg      <= '0;
            chars_reg     <= '0;
            bytes_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            bits_reg      <= bits_next;
            chars_reg     <= chars_next;
            bytes_reg     <= bytes_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg  <= out_char_next;
        line_last_reg <= line_last_next;
    end

    assign sts.bits_is_max         = (bits_reg == ule_pkg::BITS_LEFT_MAX);
    assign sts.bits_zero           = (bits_reg == '0);
    assign sts.bits_after_ge_group = (bits_reg >= ule_pkg::BITS_TWO_GROUP);
    assign sts.bits_after_zero     = (bits_reg == ule_pkg::BITS_GROUP);
    assign sts.line_full_after     = store_ok
        && ((chars_reg + ule_pkg::COUNT_W'(1)) >= ule_pkg::LINE_FULL);
    assign sts.bytes_zero          = (bytes_reg == '0);
    assign sts.chars_zero          = (chars_reg == '0);
    assign sts.rd_done             = (rd_idx_reg == chars_reg);
    assign sts.out_free            = out_free;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign line_last = line_last_reg;

endmodule

`default_nettype wire

// ===== src/uuencode_line_encoder.sv =====
// channel | signals                         | item
// --------+---------------------------------+-------------------------------
// in      | in_valid, in_stall              | data_byte, final_byte
// out     | out_valid, out_stall            | out_char, line_last
//
// a byte is taken in ST_IDLE; one that completes a three-byte group then passes ST_GROUP
// a full line (45 bytes) is replayed as length char, 60 stored chars, newline
// a final byte adds up to two zero-byte pads and three group writes, a pass
// through ST_FIN to start the flush, the line replay and a final clearing step
// the line store is read only below its fill count, so no clearing pass
// after reset; out_stall holds emission, in_stall is high while a byte is busy
`default_nettype none

module uuencode_line_encoder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input item channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ule_pkg::BYTE_W-1:0]    data_byte,
    input  wire logic                          final_byte,
    // result item channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [ule_pkg::CHAR_W-1:0]    out_char,
    output logic                               line_last
);

    // command and status between sequencer and datapath
    ule_pkg::dp_cmd_t cmd;
    ule_pkg::dp_sts_t sts;

    // sequencer: accept, group writes, padding on final, line replay
    ule_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .final_byte (final_byte),
        .sts        (sts),
        .cmd        (cmd)
    );

    // datapath: bit accumulator, counters, line store and output register
    // the output register parts the two channels, so a new byte may be taken
    // while the last character still waits downstream
    ule_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .line_last (line_last)
    );

endmodule

`default_nettype wire

// ===== src/ule_checker.sv =====
`default_nettype none
`include "uuencode_line_encoder_defines.svh"

module ule_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [7:0] data_byte,
    input wire logic       final_byte,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [6:0] out_char,
    input wire logic       line_last
);

    // stalled result holds
    `ULE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_char) && $stable(line_last))

    // line end is always a newline
    `ULE_ASSERT_NOW(a_last_is_nl, clk, rst_n, out_valid && line_last, out_char == 7'd10)

    // every other character is printable uuencode
    `ULE_ASSERT_NOW(a_char_range, clk, rst_n, out_valid && !line_last, (out_char >= 7'h21) && (out_char <= 7'h60))

    // a final byte always starts a flush
    `ULE_ASSERT_NEXT(a_final_busy, clk, rst_n, in_valid && !in_stall && final_byte, in_stall)

    // no result once reset has been seen over an edge
    `ULE_ASSERT_ALWAYS(a_reset_idle, clk, (rst_n !== 1'b0) || ($past(rst_n) !== 1'b0) || !out_valid)

endmodule

bind uuencode_line_encoder ule_checker u_ule_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .line_last  (line_last)
);

`default_nettype wire

// ===== dv/uuencode_line_checker.sv =====
module uuencode_line_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [ule_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          final_byte,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [ule_pkg::CHAR_W-1:0]    out_char,
    input  logic                          line_last,
    output int                            mismatches,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ule_pkg::CHAR_W-1:0] ch;
        logic                       nl;
    } enc_char_t;

    // encoder state as predicted
    logic [3:0]                  rem_bits;
    logic [2:0]                  rem_count;
    logic [ule_pkg::GROUP_W-1:0] group_store [ule_pkg::STORE_DEPTH];
    int unsigned                 groups_held;
    logic [5:0]                  bytes_held;

    enc_char_t expected_chars [$];
    enc_char_t want;

    function automatic logic [ule_pkg::CHAR_W-1:0] group_to_char(
        input logic [ule_pkg::GROUP_W-1:0] g);
        logic [ule_pkg::CHAR_W-1:0] c;
        if (g == '0)
            c = ule_pkg::ZERO_CHAR;
        else
            c = ule_pkg::SPACE_CHAR + ule_pkg::CHAR_W'(g);
        return c;
    endfunction

    task automatic queue_char(input logic [ule_pkg::CHAR_W-1:0] c, input logic nl);
        enc_char_t e;
        e.ch = c;
        e.nl = nl;
        expected_chars.push_back(e);
    endtask

    task automatic stash_group(input logic [ule_pkg::GROUP_W-1:0] g);
        if (groups_held < ule_pkg::STORE_DEPTH)
        begin
            group_store[groups_held] = g;
            groups_held++;
        end
    endtask

    // length char, stored chars, newline
    task automatic flush_line();
        int unsigned i;
        queue_char(group_to_char(bytes_held), 1'b0);
        for (i = 0; i < groups_held; i++)
            queue_char(group_to_char(group_store[i]), 1'b0);
        queue_char(ule_pkg::NEWLINE_CHAR, 1'b1);
        groups_held = 0;
        bytes_held  = '0;
    endtask

    task automatic encode_byte(input logic [ule_pkg::BYTE_W-1:0] b, input logic fin);
        int unsigned  nbits;
        logic [11:0]  acc;
        nbits = (rem_count > 3'd4) ? 4 : rem_count;
        acc   = {rem_bits, b};
        nbits = nbits + 8;
        bytes_held = bytes_held + 6'd1;
        while (nbits >= 6)
        begin
            nbits = nbits - 6;
            stash_group(ule_pkg::GROUP_W'(acc >> nbits));
            if (nbits == 0 && groups_held >= ule_pkg::CHARS_PER_LINE)
                flush_line();
        end
        acc = acc & ((12'd1 << nbits) - 12'd1);
        if (fin)
        begin
            // pad with zero bytes up to the end of the four-char group
            while (nbits > 0)
            begin
                if (nbits < 6)
                begin
                    acc   = acc << 8;
                    nbits = nbits + 8;
                end
                nbits = nbits - 6;
                stash_group(ule_pkg::GROUP_W'(acc >> nbits));
                acc = acc & ((12'd1 << nbits) - 12'd1);
            end
            if (bytes_held != '0)
                flush_line();
            groups_held = 0;
            bytes_held  = '0;
            acc         = '0;
            nbits       = 0;
        end
        rem_bits  = acc[3:0];
        rem_count = 3'(nbits);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_bits    = '0;
            rem_count   = '0;
            groups_held = 0;
            bytes_held  = '0;
            expected_chars.delete();
            mismatches  = 0;
            pending     = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                encode_byte(data_byte, final_byte);
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t: unexpected char 0x%02h last %0d, nothing pending",
                                 $realtime, out_char, line_last);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (want.ch !== out_char || want.nl !== line_last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%t: expected char 0x%02h last %0d, got 0x%02h last %0d",
                                     $realtime, want.ch, want.nl, out_char, line_last);
                    end
                end
            end
            pending = expected_chars.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // how a stream's bytes are filled
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    // rough item count at which the random part stops
    localparam int TARGET_ITEMS = 380;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [ule_pkg::BYTE_W-1:0] data_byte;
    logic                       final_byte;
    logic                       out_valid;
    logic                       out_stall;
    logic [ule_pkg::CHAR_W-1:0] out_char;
    logic                       line_last;

    int mismatches;
    int pending;
    int items_sent;

    uuencode_line_encoder uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .line_last  (line_last)
    );

    // watches both channels, predicts every char and compares
    uuencode_line_checker line_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .line_last  (line_last),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard limit, far beyond the slowest correct run
    initial
    begin
        #(20ms);
        $display("CHECKS FAILED");
        $finish;
    end

    // gap before an item: mostly none, sometimes short, rarely long;
    // tight streams never idle
    function automatic int pick_gap(input bit tight);
        int r;
        int g;
        r = $urandom_range(0, 99);
        if (tight || r < 55)
            g = 0;
        else if (r < 92)
            g = $urandom_range(1, 3);
        else
            g = $urandom_range(10, 40);
        return g;
    endfunction

    // offers one item after a gap and returns once it has been taken;
    // valid stays high straight into the next item when there is no gap
    task automatic push_byte(input logic [ule_pkg::BYTE_W-1:0] b, input logic fin,
                             input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        data_byte  <= b;
        final_byte <= fin;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // hold the sender until every predicted char has come out
    task automatic drain_output();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // one stream ending in a final byte; now and then a stray final
    // byte mid-stream splits it in two
    task automatic send_stream(input int len, input int fill, input bit tight);
        int k;
        logic [ule_pkg::BYTE_W-1:0] b;
        logic fin;
        for (k = 0; k < len; k++)
        begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = ule_pkg::BYTE_W'($urandom);
            endcase
            fin = (k == len - 1) || ($urandom_range(0, 39) == 0);
            push_byte(b, fin, pick_gap(tight));
        end
    endtask

    // receiver back-pressure in runs: quiet stretches, short bursts
    // either way and the odd long stall
    initial
    begin
        int r;
        int run_len;
        logic hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                hold    = 1'b0;
                run_len = $urandom_range(50, 200);
            end
            else if (r < 55)
            begin
                hold    = 1'b0;
                run_len = $urandom_range(1, 4);
            end
            else if (r < 95)
            begin
                hold    = 1'b1;
                run_len = $urandom_range(1, 4);
            end
            else
            begin
                hold    = 1'b1;
                run_len = $urandom_range(15, 60);
            end
            @(negedge clk);
            out_stall <= hold;
            repeat (run_len - 1) @(negedge clk);
        end
    end

    initial
    begin
        int r;
        int len;
        int fill;
        bit tight;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = '0;
        final_byte = 1'b0;
        items_sent = 0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed part: short streams covering every leftover-bit phase
        // single zero byte: all-zero groups map to backquote
        push_byte(8'h00, 1'b1, 0);
        // single all-ones byte, padded with two zero bytes
        push_byte(8'hFF, 1'b1, 0);
        // two bytes, padded with one zero byte
        push_byte(8'hFF, 1'b0, 0);
        push_byte(8'h00, 1'b1, 1);
        // three bytes: exact group, no padding
        push_byte(8'h80, 1'b0, 0);
        push_byte(8'h01, 1'b0, 0);
        push_byte(8'hFE, 1'b1, 0);
        // four bytes: a full group then one padded group
        push_byte(8'h55, 1'b0, 0);
        push_byte(8'hAA, 1'b0, 2);
        push_byte(8'h0F, 1'b0, 0);
        push_byte(8'hF0, 1'b1, 0);
        // groups of all zeros and all ones
        push_byte(8'h00, 1'b0, 0);
        push_byte(8'h00, 1'b0, 0);
        push_byte(8'h00, 1'b1, 0);
        push_byte(8'hFF, 1'b0, 0);
        push_byte(8'hFF, 1'b0, 0);
        push_byte(8'hFF, 1'b1, 0);

        // sender waits for the whole backlog once before the random part
        drain_output();

        // random streams: lengths favour one line exactly (final on the
        // byte that completes it), one either side, two lines, and tiny
        // streams; the rest spread over a partial line
        while (items_sent < TARGET_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                len = 45;
            else if (r < 20)
                len = $urandom_range(0, 1) ? 44 : 46;
            else if (r < 25)
                len = 90;
            else if (r < 35)
                len = $urandom_range(1, 3);
            else
                len = $urandom_range(1, 40);

            r = $urandom_range(0, 99);
            if (r < 8)
                fill = FILL_ZERO;
            else if (r < 16)
                fill = FILL_ONES;
            else
                fill = FILL_RANDOM;

            tight = ($urandom_range(0, 3) == 0);
            send_stream(len, fill, tight);

            if ($urandom_range(0, 5) == 0)
                drain_output();
        end

        // wait for every predicted char, then let the block settle
        drain_output();
        repeat (80) @(negedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
